// ----- design/mca_pkg.sv -----
// ----------------------------------------------------------------------------
// mca_pkg: shared types and constants of the minimum-cost arborescence unit
// Widths, sentinels, register indexes, datapath operations and status bundle.
// ----------------------------------------------------------------------------
`default_nettype none
package mca_pkg;

	localparam int MAX_NODES   = 1024;
	localparam int MAX_EDGES   = 16384;
	localparam int WEIGHT_BITS = 16;

	localparam int NODE_BITS   = $clog2(MAX_NODES);
	localparam int NCNT_BITS   = NODE_BITS + 1;
	localparam int LABEL_BITS  = NODE_BITS + 1;
	localparam int EADDR_BITS  = $clog2(MAX_EDGES);
	localparam int ECNT_BITS   = EADDR_BITS + 1;
	localparam int COST_BITS   = WEIGHT_BITS + 1;
	localparam int EDGE_BITS   = 2 * NODE_BITS + WEIGHT_BITS;
	localparam int TOTAL_BITS  = 26;

	// Stream field layout (fixed by the field widths of the interface).
	localparam int IN_NODE_BITS   = 10;
	localparam int IN_WEIGHT_BITS = 16;
	localparam int S_TDATA_BITS   = 40;
	localparam int M_TDATA_BITS   = 32;
	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS  = 11;
	localparam int CFG_COUNT_BITS = 11;
	localparam int CFG_ROOT_BITS  = 10;

	localparam logic [COST_BITS-1:0]  NO_EDGE     = COST_BITS'(1) << WEIGHT_BITS;
	localparam logic [LABEL_BITS-1:0] UNSET_LABEL = '1;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX   = '1;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_NODE_COUNT = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ROOT_NODE  = 8'd1;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_INIT, OP_SAN_RD, OP_SAN_WR, OP_CLR,
		OP_SEL_RD, OP_SEL_NODE, OP_SEL_UPD, OP_ROOT, OP_CHK_RD, OP_CHK_EV,
		OP_WALK_START, OP_WALK_RD, OP_WALK_EV, OP_MARK_RD, OP_MARK_EV, OP_NEXT_I,
		OP_REST_RD, OP_REST_EV, OP_RL_RD, OP_RL_LU, OP_RL_LV, OP_RL_WR,
		OP_RT_RD, OP_RT_EV, OP_FIN_OK, OP_FIN_FAIL
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_INIT, ST_SAN_RD, ST_SAN_WR, ST_CLR,
		ST_SEL_RD, ST_SEL_NODE, ST_SEL_UPD, ST_ROOT, ST_CHK_RD, ST_CHK_EV,
		ST_WALK_START, ST_WALK_RD, ST_WALK_EV, ST_MARK_RD, ST_MARK_EV, ST_NEXT_I,
		ST_REST_RD, ST_REST_EV, ST_RL_RD, ST_RL_LU, ST_RL_LV, ST_RL_WR,
		ST_RT_RD, ST_RT_EV, ST_FIN_OK, ST_FIN_FAIL
	} state_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic e_done;
		logic i_done;
		logic root_bad;
		logic no_edge;
		logic walk_go;
		logic mark_start;
		logic mark_go;
		logic k_zero;
		logic res_busy;
	} stat_t;

endpackage
`default_nettype wire

// ----- design/mca_ram.sv -----
// ----------------------------------------------------------------------------
// mca_ram: generic single-write, single-read memory
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none
module mca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- design/mca_ctrl.sv -----
// ----------------------------------------------------------------------------
// mca_ctrl: sequencer of the contraction passes
// Steps the datapath through load, selection, cycle search and relabeling.
// ----------------------------------------------------------------------------
`default_nettype none
module mca_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	input  wire logic           s_tlast,
	output logic                s_tready,
	input  wire mca_pkg::stat_t stat,
	output mca_pkg::cmd_t       cmd
);

	mca_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mca_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = mca_pkg::OP_NONE;
		s_tready = 1'b0;
		case (state_q)
			mca_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op = mca_pkg::OP_LOAD;
					if (s_tlast) state_d = mca_pkg::ST_INIT;
				end
			end
			mca_pkg::ST_INIT: begin
				cmd.op  = mca_pkg::OP_INIT;
				state_d = stat.root_bad ? mca_pkg::ST_FIN_FAIL : mca_pkg::ST_SAN_RD;
			end
			mca_pkg::ST_SAN_RD: begin
				cmd.op  = mca_pkg::OP_SAN_RD;
				state_d = stat.e_done ? mca_pkg::ST_CLR : mca_pkg::ST_SAN_WR;
			end
			mca_pkg::ST_SAN_WR: begin
				cmd.op  = mca_pkg::OP_SAN_WR;
				state_d = mca_pkg::ST_SAN_RD;
			end
			mca_pkg::ST_CLR: begin
				cmd.op = mca_pkg::OP_CLR;
				if (stat.i_done) state_d = mca_pkg::ST_SEL_RD;
			end
			mca_pkg::ST_SEL_RD: begin
				cmd.op  = mca_pkg::OP_SEL_RD;
				state_d = stat.e_done ? mca_pkg::ST_ROOT : mca_pkg::ST_SEL_NODE;
			end
			mca_pkg::ST_SEL_NODE: begin
				cmd.op  = mca_pkg::OP_SEL_NODE;
				state_d = mca_pkg::ST_SEL_UPD;
			end
			mca_pkg::ST_SEL_UPD: begin
				cmd.op  = mca_pkg::OP_SEL_UPD;
				state_d = mca_pkg::ST_SEL_RD;
			end
			mca_pkg::ST_ROOT: begin
				cmd.op  = mca_pkg::OP_ROOT;
				state_d = mca_pkg::ST_CHK_RD;
			end
			mca_pkg::ST_CHK_RD: begin
				cmd.op  = mca_pkg::OP_CHK_RD;
				state_d = stat.i_done ? mca_pkg::ST_WALK_START : mca_pkg::ST_CHK_EV;
			end
			mca_pkg::ST_CHK_EV: begin
				cmd.op  = mca_pkg::OP_CHK_EV;
				state_d = stat.no_edge ? mca_pkg::ST_FIN_FAIL : mca_pkg::ST_CHK_RD;
			end
			mca_pkg::ST_WALK_START: begin
				cmd.op = mca_pkg::OP_WALK_START;
				if (!stat.i_done) state_d = mca_pkg::ST_WALK_RD;
				else if (stat.k_zero) state_d = mca_pkg::ST_FIN_OK;
				else state_d = mca_pkg::ST_REST_RD;
			end
			mca_pkg::ST_WALK_RD: begin
				cmd.op  = mca_pkg::OP_WALK_RD;
				state_d = mca_pkg::ST_WALK_EV;
			end
			mca_pkg::ST_WALK_EV: begin
				cmd.op = mca_pkg::OP_WALK_EV;
				if (stat.walk_go) state_d = mca_pkg::ST_WALK_RD;
				else if (stat.mark_start) state_d = mca_pkg::ST_MARK_RD;
				else state_d = mca_pkg::ST_NEXT_I;
			end
			mca_pkg::ST_MARK_RD: begin
				cmd.op  = mca_pkg::OP_MARK_RD;
				state_d = mca_pkg::ST_MARK_EV;
			end
			mca_pkg::ST_MARK_EV: begin
				cmd.op  = mca_pkg::OP_MARK_EV;
				state_d = stat.mark_go ? mca_pkg::ST_MARK_RD : mca_pkg::ST_NEXT_I;
			end
			mca_pkg::ST_NEXT_I: begin
				cmd.op  = mca_pkg::OP_NEXT_I;
				state_d = mca_pkg::ST_WALK_START;
			end
			mca_pkg::ST_REST_RD: begin
				cmd.op  = mca_pkg::OP_REST_RD;
				state_d = stat.i_done ? mca_pkg::ST_RL_RD : mca_pkg::ST_REST_EV;
			end
			mca_pkg::ST_REST_EV: begin
				cmd.op  = mca_pkg::OP_REST_EV;
				state_d = mca_pkg::ST_REST_RD;
			end
			mca_pkg::ST_RL_RD: begin
				cmd.op  = mca_pkg::OP_RL_RD;
				state_d = stat.e_done ? mca_pkg::ST_RT_RD : mca_pkg::ST_RL_LU;
			end
			mca_pkg::ST_RL_LU: begin
				cmd.op  = mca_pkg::OP_RL_LU;
				state_d = mca_pkg::ST_RL_LV;
			end
			mca_pkg::ST_RL_LV: begin
				cmd.op  = mca_pkg::OP_RL_LV;
				state_d = mca_pkg::ST_RL_WR;
			end
			mca_pkg::ST_RL_WR: begin
				cmd.op  = mca_pkg::OP_RL_WR;
				state_d = mca_pkg::ST_RL_RD;
			end
			mca_pkg::ST_RT_RD: begin
				cmd.op  = mca_pkg::OP_RT_RD;
				state_d = mca_pkg::ST_RT_EV;
			end
			mca_pkg::ST_RT_EV: begin
				cmd.op  = mca_pkg::OP_RT_EV;
				state_d = mca_pkg::ST_CLR;
			end
			mca_pkg::ST_FIN_OK: begin
				if (!stat.res_busy) begin
					cmd.op  = mca_pkg::OP_FIN_OK;
					state_d = mca_pkg::ST_IDLE;
				end
			end
			mca_pkg::ST_FIN_FAIL: begin
				if (!stat.res_busy) begin
					cmd.op  = mca_pkg::OP_FIN_FAIL;
					state_d = mca_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mca_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- design/mca_dpath.sv -----
// ----------------------------------------------------------------------------
// mca_dpath: edge store, per-node work memories, counters and result register
// Carries out one operation per cycle as commanded by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module mca_dpath (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire mca_pkg::cmd_t                        cmd,
	output mca_pkg::stat_t                            stat,
	input  wire logic [mca_pkg::S_TDATA_BITS-1:0]     s_tdata,
	output logic      [mca_pkg::M_TDATA_BITS-1:0]     m_tdata,
	output logic      [0:0]                           m_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [mca_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [mca_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	localparam int N  = mca_pkg::NODE_BITS;
	localparam int NC = mca_pkg::NCNT_BITS;
	localparam int L  = mca_pkg::LABEL_BITS;
	localparam int W  = mca_pkg::WEIGHT_BITS;
	localparam int C  = mca_pkg::COST_BITS;
	localparam int EA = mca_pkg::EADDR_BITS;
	localparam int EC = mca_pkg::ECNT_BITS;
	localparam int T  = mca_pkg::TOTAL_BITS;
	localparam int EW = mca_pkg::EDGE_BITS;

	// Control registers.
	logic [NC-1:0] node_count_q;
	logic [N-1:0]  root_node_q;
	logic [EC-1:0] ecnt_q, e_q;
	logic [NC-1:0] i_q, k_q, live_n_q;
	logic [N-1:0]  live_root_q;
	logic [T-1:0]  total_q;
	logic          res_valid_q;

	// Payload registers.
	logic [N-1:0]  x_q, eu_q, ev_q;
	logic [W-1:0]  ew_q;
	logic [L-1:0]  p_q;
	logic [T-1:0]  res_total_q;
	logic          res_imp_q;

	// Memory ports.
	logic          edge_we, edge_re;
	logic [EA-1:0] edge_waddr, edge_raddr;
	logic [EW-1:0] edge_wdata, edge_rd;
	logic          cost_we, cost_re;
	logic [N-1:0]  cost_waddr, cost_raddr;
	logic [C-1:0]  cost_wdata, cost_rd;
	logic          par_we, par_re;
	logic [N-1:0]  par_waddr, par_raddr;
	logic [N-1:0]  par_wdata, par_rd;
	logic          lab_we, lab_re;
	logic [N-1:0]  lab_waddr, lab_raddr;
	logic [L-1:0]  lab_wdata, lab_rd;
	logic          vis_we, vis_re;
	logic [N-1:0]  vis_waddr, vis_raddr;
	logic [L-1:0]  vis_wdata, vis_rd;

	logic [N-1:0]  ed_src, ed_dst, in_src, in_dst;
	logic [W-1:0]  ed_w, in_w, w_adj;
	logic [NC-1:0] n_clamp;
	logic [T:0]    sum;
	logic          edge_out;

	assign ed_src = edge_rd[N-1:0];
	assign ed_dst = edge_rd[2*N-1:N];
	assign ed_w   = edge_rd[EW-1:2*N];
	assign in_src = s_tdata[N-1:0];
	assign in_dst = s_tdata[mca_pkg::IN_NODE_BITS +: N];
	assign in_w   = s_tdata[2*mca_pkg::IN_NODE_BITS +: W];

	always_comb begin
		if (node_count_q == '0) n_clamp = NC'(1);
		else if (node_count_q > NC'(mca_pkg::MAX_NODES)) n_clamp = NC'(mca_pkg::MAX_NODES);
		else n_clamp = node_count_q;
	end

	assign edge_out = ({1'b0, ed_src} >= live_n_q) || ({1'b0, ed_dst} >= live_n_q);
	assign sum      = {1'b0, total_q} + (T+1)'(cost_rd);
	assign w_adj    = (p_q != lab_rd) ? (ew_q - cost_rd[W-1:0]) : ew_q;

	always_comb begin
		stat.e_done     = (e_q == ecnt_q);
		stat.i_done     = (i_q == live_n_q);
		stat.root_bad   = ({1'b0, root_node_q} >= n_clamp);
		stat.no_edge    = (cost_rd == mca_pkg::NO_EDGE);
		stat.mark_go    = (lab_rd == mca_pkg::UNSET_LABEL);
		stat.mark_start = (x_q != live_root_q) && stat.mark_go;
		stat.walk_go    = stat.mark_start && (vis_rd != i_q);
		stat.k_zero     = (k_q == '0);
		stat.res_busy   = res_valid_q && !m_tready;
	end

	// Memory addressing for each operation.
	always_comb begin
		edge_we = 1'b0; edge_waddr = e_q[EA-1:0]; edge_wdata = edge_rd;
		edge_re = 1'b0; edge_raddr = e_q[EA-1:0];
		cost_we = 1'b0; cost_waddr = i_q[N-1:0]; cost_wdata = mca_pkg::NO_EDGE;
		cost_re = 1'b0; cost_raddr = i_q[N-1:0];
		par_we  = 1'b0; par_waddr  = i_q[N-1:0]; par_wdata  = '0;
		par_re  = 1'b0; par_raddr  = x_q;
		lab_we  = 1'b0; lab_waddr  = i_q[N-1:0]; lab_wdata  = mca_pkg::UNSET_LABEL;
		lab_re  = 1'b0; lab_raddr  = x_q;
		vis_we  = 1'b0; vis_waddr  = i_q[N-1:0]; vis_wdata  = mca_pkg::UNSET_LABEL;
		vis_re  = 1'b0; vis_raddr  = x_q;
		case (cmd.op)
			mca_pkg::OP_LOAD: begin
				edge_we    = (ecnt_q < EC'(mca_pkg::MAX_EDGES));
				edge_waddr = ecnt_q[EA-1:0];
				edge_wdata = {in_w, in_dst, in_src};
			end
			mca_pkg::OP_SAN_RD, mca_pkg::OP_SEL_RD, mca_pkg::OP_RL_RD: begin
				edge_re = !stat.e_done;
			end
			mca_pkg::OP_SAN_WR: begin
				edge_we    = edge_out;
				edge_wdata = {ed_w, {(2*N){1'b0}}};
			end
			mca_pkg::OP_CLR: begin
				cost_we = !stat.i_done;
				par_we  = !stat.i_done;
				lab_we  = !stat.i_done;
				vis_we  = !stat.i_done;
			end
			mca_pkg::OP_SEL_NODE: begin
				cost_re    = 1'b1;
				cost_raddr = ed_dst;
			end
			mca_pkg::OP_SEL_UPD: begin
				cost_we    = (eu_q != ev_q) && ({1'b0, ew_q} < cost_rd);
				cost_waddr = ev_q;
				cost_wdata = {1'b0, ew_q};
				par_we     = cost_we;
				par_waddr  = ev_q;
				par_wdata  = eu_q;
			end
			mca_pkg::OP_ROOT: begin
				cost_we    = 1'b1;
				cost_waddr = live_root_q;
				cost_wdata = '0;
			end
			mca_pkg::OP_CHK_RD: begin
				cost_re = !stat.i_done;
			end
			mca_pkg::OP_WALK_RD: begin
				vis_re = 1'b1;
				lab_re = 1'b1;
				par_re = 1'b1;
			end
			mca_pkg::OP_WALK_EV: begin
				vis_we    = stat.walk_go;
				vis_waddr = x_q;
				vis_wdata = i_q;
			end
			mca_pkg::OP_MARK_RD: begin
				lab_re = 1'b1;
				par_re = 1'b1;
			end
			mca_pkg::OP_MARK_EV: begin
				lab_we    = stat.mark_go;
				lab_waddr = x_q;
				lab_wdata = k_q;
			end
			mca_pkg::OP_REST_RD: begin
				lab_re    = !stat.i_done;
				lab_raddr = i_q[N-1:0];
			end
			mca_pkg::OP_REST_EV: begin
				lab_we    = stat.mark_go;
				lab_wdata = k_q;
			end
			mca_pkg::OP_RL_LU: begin
				lab_re    = 1'b1;
				lab_raddr = ed_src;
			end
			mca_pkg::OP_RL_LV: begin
				lab_re     = 1'b1;
				lab_raddr  = ev_q;
				cost_re    = 1'b1;
				cost_raddr = ev_q;
			end
			mca_pkg::OP_RL_WR: begin
				edge_we    = 1'b1;
				edge_wdata = {w_adj, lab_rd[N-1:0], p_q[N-1:0]};
			end
			mca_pkg::OP_RT_RD: begin
				lab_re    = 1'b1;
				lab_raddr = live_root_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NC'(1);
			root_node_q  <= '0;
			ecnt_q       <= '0;
			e_q          <= '0;
			i_q          <= '0;
			k_q          <= '0;
			live_n_q     <= '0;
			live_root_q  <= '0;
			total_q      <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == mca_pkg::CFG_NODE_COUNT) begin
					node_count_q <= cfg_data[NC-1:0];
				end else if (cfg_index == mca_pkg::CFG_ROOT_NODE) begin
					root_node_q <= cfg_data[N-1:0];
				end
			end
			// A finishing solve refills the result register in the same cycle.
			if (res_valid_q && m_tready && cmd.op != mca_pkg::OP_FIN_OK
					&& cmd.op != mca_pkg::OP_FIN_FAIL) begin
				res_valid_q <= 1'b0;
			end
			case (cmd.op)
				mca_pkg::OP_LOAD: begin
					if (ecnt_q < EC'(mca_pkg::MAX_EDGES)) ecnt_q <= ecnt_q + 1'b1;
				end
				mca_pkg::OP_INIT: begin
					live_n_q    <= n_clamp;
					live_root_q <= root_node_q;
					total_q     <= '0;
					e_q         <= '0;
					i_q         <= '0;
				end
				mca_pkg::OP_SAN_RD, mca_pkg::OP_SEL_RD, mca_pkg::OP_RL_RD: begin
					if (stat.e_done) e_q <= '0;
				end
				mca_pkg::OP_SAN_WR, mca_pkg::OP_SEL_UPD, mca_pkg::OP_RL_WR: begin
					e_q <= e_q + 1'b1;
				end
				mca_pkg::OP_CLR: begin
					i_q <= stat.i_done ? '0 : i_q + 1'b1;
				end
				mca_pkg::OP_ROOT: begin
					k_q <= '0;
				end
				mca_pkg::OP_CHK_RD, mca_pkg::OP_REST_RD, mca_pkg::OP_WALK_START: begin
					if (stat.i_done) i_q <= '0;
				end
				mca_pkg::OP_CHK_EV: begin
					if (!stat.no_edge) begin
						total_q <= (sum > {1'b0, mca_pkg::TOTAL_MAX}) ? mca_pkg::TOTAL_MAX
							: sum[T-1:0];
						i_q <= i_q + 1'b1;
					end
				end
				mca_pkg::OP_MARK_EV: begin
					if (!stat.mark_go) k_q <= k_q + 1'b1;
				end
				mca_pkg::OP_NEXT_I: begin
					i_q <= i_q + 1'b1;
				end
				mca_pkg::OP_REST_EV: begin
					if (stat.mark_go) k_q <= k_q + 1'b1;
					i_q <= i_q + 1'b1;
				end
				mca_pkg::OP_RT_EV: begin
					live_root_q <= lab_rd[N-1:0];
					live_n_q    <= k_q;
				end
				mca_pkg::OP_FIN_OK, mca_pkg::OP_FIN_FAIL: begin
					res_valid_q <= 1'b1;
					ecnt_q      <= '0;
					e_q         <= '0;
					i_q         <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			mca_pkg::OP_SEL_NODE, mca_pkg::OP_RL_LU: begin
				eu_q <= ed_src;
				ev_q <= ed_dst;
				ew_q <= ed_w;
			end
			mca_pkg::OP_WALK_START: begin
				x_q <= i_q[N-1:0];
			end
			mca_pkg::OP_WALK_EV: begin
				if (stat.walk_go) x_q <= par_rd;
			end
			mca_pkg::OP_MARK_EV: begin
				if (stat.mark_go) x_q <= par_rd;
			end
			mca_pkg::OP_RL_LV: begin
				p_q <= lab_rd;
			end
			mca_pkg::OP_FIN_OK: begin
				res_total_q <= total_q;
				res_imp_q   <= 1'b0;
			end
			mca_pkg::OP_FIN_FAIL: begin
				res_total_q <= '0;
				res_imp_q   <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = res_valid_q;
	assign m_tdata   = mca_pkg::M_TDATA_BITS'(res_total_q);
	assign m_tuser   = res_imp_q;

	mca_ram #(.WIDTH(EW), .DEPTH(mca_pkg::MAX_EDGES)) u_edge_ram (
		.clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
		.re(edge_re), .raddr(edge_raddr), .rdata(edge_rd)
	);

	mca_ram #(.WIDTH(C), .DEPTH(mca_pkg::MAX_NODES)) u_cost_ram (
		.clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
		.re(cost_re), .raddr(cost_raddr), .rdata(cost_rd)
	);

	mca_ram #(.WIDTH(N), .DEPTH(mca_pkg::MAX_NODES)) u_parent_ram (
		.clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
		.re(par_re), .raddr(par_raddr), .rdata(par_rd)
	);

	mca_ram #(.WIDTH(L), .DEPTH(mca_pkg::MAX_NODES)) u_label_ram (
		.clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
		.re(lab_re), .raddr(lab_raddr), .rdata(lab_rd)
	);

	mca_ram #(.WIDTH(L), .DEPTH(mca_pkg::MAX_NODES)) u_visit_ram (
		.clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
		.re(vis_re), .raddr(vis_raddr), .rdata(vis_rd)
	);

endmodule
`default_nettype wire

// ----- design/min_cost_arborescence_unit.sv -----
// ----------------------------------------------------------------------------
// min_cost_arborescence_unit: directed minimum spanning tree engine
// Stores a stream of weighted edges and solves for the cheapest arborescence.
// ----------------------------------------------------------------------------
// Edges load at one beat per cycle into the edge memory. The beat with tlast
// starts the solver, which holds off new edges until its result is stored.
// A finished solve waits while an earlier result is still unaccepted. Reset
// clears all control state; memories are not cleared because every pass
// writes each node entry before it reads it.
`default_nettype none
module min_cost_arborescence_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Edge stream. s_tdata, from bit 0 up: edge_source, edge_target,
	// edge_weight, four zero bits. s_tlast is last_edge.
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [mca_pkg::S_TDATA_BITS-1:0]     s_tdata,
	input  wire logic                                 s_tlast,
	// Result stream. m_tdata, from bit 0 up: total_cost, six zero bits.
	// m_tuser holds impossible.
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic      [mca_pkg::M_TDATA_BITS-1:0]     m_tdata,
	output logic      [0:0]                           m_tuser,
	// Register writes: index 0 is node_count, index 1 is root_node.
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [mca_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [mca_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	mca_pkg::cmd_t  cmd;
	mca_pkg::stat_t stat;

	// The sequencer owns the edge handshake, sanitizes the edges once and then
	// walks the datapath through each pass: clear, select, check and sum,
	// cycle search, labeling and edge relabeling.
	mca_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tlast(s_tlast),
		.s_tready(s_tready),
		.stat(stat),
		.cmd(cmd)
	);

	// The datapath holds the edge memory, the four per-node work memories,
	// the loop counters and the result register.
	mca_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.s_tdata(s_tdata),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// An impossible result always carries a zero total.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
		else $error("impossible result with nonzero total");

	// The final edge beat hands control to the solver at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("edge stream still open after final edge");

	// A new result is only produced while the solver is busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared while loading edges");

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for min_cost_arborescence_unit
// Streams directed weighted graphs into the unit and checks every answer
// against a behavioral Chu-Liu/Edmonds solver kept inside the bench.
// ----------------------------------------------------------------------------
// The run starts with a short directed table of graphs and register writes,
// and then sends random graphs. Most random graphs are well formed: every
// non-root node gets a parent, so the solver has to find and contract cycles.
// The rest are noise, graphs with a missing parent, or graphs with endpoints
// out of range.
// Register writes only happen once every expected answer has come back and
// the unit has had time to settle.
`default_nettype none
module tb_top;
	import mca_pkg::*;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 8'd5;   // not a register
	localparam int HOLD_CYCLES   = 500;
	localparam int STALL_LIMIT   = 600000;
	localparam int RANDOM_ITEMS  = 1150;
	localparam int UNSET_MARK    = 'hFFFF;

	typedef enum {ROW_CFG, ROW_EDGE} row_kind_e;

	// One row of the directed table. For a register write, a is the index
	// and b the data; for an edge, a is the source and b the target.
	typedef struct {
		row_kind_e kind;
		int        a;
		int        b;
		int        weight;
		bit        last;
		bit        typed;
		int        total;
		bit        impossible;
	} row_t;

	typedef struct {
		logic [TOTAL_BITS-1:0] total;
		logic                  impossible;
	} answer_t;

	typedef struct {
		int src;
		int dst;
		int weight;
	} edge_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_TDATA_BITS-1:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [M_TDATA_BITS-1:0] m_tdata;
	logic [0:0] m_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	min_cost_arborescence_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Mirror of the unit's registers and edge memory.
	int       model_node_count = 1;
	int       model_root = 0;
	int       graph_src[MAX_EDGES];
	int       graph_dst[MAX_EDGES];
	int       graph_weight[MAX_EDGES];
	int       graph_edges = 0;
	// Per-node work arrays of the solver.
	int       best_cost[MAX_NODES];
	int       best_parent[MAX_NODES];
	int       cycle_id[MAX_NODES];
	int       walk_tag[MAX_NODES];

	answer_t  pending_answers[$];
	int       errors = 0;
	int       answers_seen = 0;
	int       impossible_seen = 0;
	int       edges_sent = 0;
	int       graphs_sent = 0;
	int       stalled_cycles = 0;
	bit       quiet = 0;          // no idling on either side while set
	int       hold_requests = 0;
	int       hold_served = 0;
	int       hold_left = 0;

	// Clock with a period of two units.
	initial clk = 0;
	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// Chu-Liu/Edmonds on the stored edges, with the unit's clamping and
	// sentinel rules. Returns the answer that the unit must give.
	function automatic answer_t solve_arborescence();
		answer_t ans;
		int n, live_n, live_root, k, x, p, q;
		longint total;
		ans.total = '0;
		ans.impossible = 1'b1;
		n = model_node_count;
		if (n < 1) n = 1;
		if (n > MAX_NODES) n = MAX_NODES;
		live_n = n;
		live_root = model_root;
		total = 0;
		if (live_root >= n) return ans;
		// Edges touching a node outside the graph become harmless self-loops.
		for (int e = 0; e < graph_edges; e++)
			if (graph_src[e] >= n || graph_dst[e] >= n) begin
				graph_src[e] = 0;
				graph_dst[e] = 0;
			end
		forever begin
			n = live_n;
			for (int i = 0; i < n; i++) begin
				best_cost[i] = 1 << WEIGHT_BITS;
				best_parent[i] = 0;
				cycle_id[i] = UNSET_MARK;
				walk_tag[i] = UNSET_MARK;
			end
			// Cheapest incoming edge per node; on a tie the earlier edge wins.
			for (int e = 0; e < graph_edges; e++)
				if (graph_src[e] != graph_dst[e] &&
						graph_weight[e] < best_cost[graph_dst[e]]) begin
					best_cost[graph_dst[e]] = graph_weight[e];
					best_parent[graph_dst[e]] = graph_src[e];
				end
			best_cost[live_root] = 0;
			for (int i = 0; i < n; i++)
				if (best_cost[i] == (1 << WEIGHT_BITS)) return ans;
			for (int i = 0; i < n; i++) begin
				total += best_cost[i];
				if (total > TOTAL_MAX) total = TOTAL_MAX;
			end
			// Follow parent pointers; a walk that returns to its own tag has
			// found a new cycle, which gets the next label.
			k = 0;
			for (int i = 0; i < n; i++) begin
				x = i;
				while (x != live_root && walk_tag[x] != i && cycle_id[x] == UNSET_MARK) begin
					walk_tag[x] = i;
					x = best_parent[x];
				end
				if (x != live_root && cycle_id[x] == UNSET_MARK) begin
					while (cycle_id[x] == UNSET_MARK) begin
						cycle_id[x] = k;
						x = best_parent[x];
					end
					k++;
				end
			end
			if (k == 0) break;
			for (int i = 0; i < n; i++)
				if (cycle_id[i] == UNSET_MARK) cycle_id[i] = k++;
			// Contract: edges between groups pay only the extra over the
			// target's chosen cost.
			for (int e = 0; e < graph_edges; e++) begin
				p = cycle_id[graph_src[e]];
				q = cycle_id[graph_dst[e]];
				if (p != q) graph_weight[e] -= best_cost[graph_dst[e]];
				graph_src[e] = p;
				graph_dst[e] = q;
			end
			live_root = cycle_id[live_root];
			live_n = k;
		end
		ans.total = total[TOTAL_BITS-1:0];
		ans.impossible = 1'b0;
		return ans;
	endfunction

	// Called for every accepted edge beat. Returns the expected answer when
	// the beat closes a graph.
	function automatic bit absorb_edge(int src, int dst, int weight, bit last,
			output answer_t ans);
		if (graph_edges < MAX_EDGES) begin
			graph_src[graph_edges] = src;
			graph_dst[graph_edges] = dst;
			graph_weight[graph_edges] = weight;
			graph_edges++;
		end
		ans = '{default: '0};
		if (!last) return 0;
		ans = solve_arborescence();
		graph_edges = 0;
		return 1;
	endfunction

	// Offers one edge beat and waits for it to be taken. On return the bench
	// is at a falling edge with valid still up; the caller drives it next.
	task automatic send_edge(int src, int dst, int weight, bit last, bit typed = 0,
			answer_t typed_ans = '{default: '0});
		answer_t ans;
		while (!quiet && $urandom_range(99) < 14) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, 16'(weight), 10'(dst), 10'(src)};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		if (absorb_edge(src, dst, weight, last, ans)) begin
			pending_answers = {pending_answers, (typed ? typed_ans : ans)};
			graphs_sent++;
		end
		edges_sent++;
		@(negedge clk);
	endtask

	// Drops valid and waits until every answer is back, plus a settling gap.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_answers.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, int value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= CFG_DATA_BITS'(value);
		do @(posedge clk); while (!cfg_ready);
		if (index == CFG_NODE_COUNT) model_node_count = value & 'h7FF;
		else if (index == CFG_ROOT_NODE) model_root = value & 'h3FF;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One random graph for the current registers. Returns the edge count.
	task automatic send_random_graph(output int sent);
		edge_t edges[$];
		edge_t tmp;
		int n, root, style, skip, j;
		n = model_node_count < 1 ? 1 : (model_node_count > MAX_NODES ? MAX_NODES
			: model_node_count);
		root = model_root;
		style = $urandom_range(99);
		if (root >= n || n > 64 || style < 15) begin
			// Noise: endpoints anywhere in the field range.
			repeat ($urandom_range(1, 8)) begin
				tmp.src = $urandom_range(0, 1023);
				tmp.dst = $urandom_range(0, 1023);
				tmp.weight = $urandom_range(0, 65535);
				edges = {edges, tmp};
			end
		end else begin
			// Every non-root node gets a parent, except one in broken graphs.
			skip = style < 25 ? $urandom_range(0, n - 1) : -1;
			for (int v = 0; v < n; v++) begin
				if (v == root || v == skip || n < 2) continue;
				do tmp.src = $urandom_range(0, n - 1); while (tmp.src == v);
				tmp.dst = v;
				tmp.weight = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
					: $urandom_range(0, 15);
				edges = {edges, tmp};
			end
			repeat ($urandom_range(0, 5)) begin
				tmp.src = $urandom_range(0, n - 1);
				tmp.dst = $urandom_range(0, n - 1);
				tmp.weight = $urandom_range(0, 1) ? $urandom_range(0, 65535)
					: $urandom_range(0, 15);
				if (skip >= 0 && tmp.dst == skip) tmp.dst = root;
				edges = {edges, tmp};
			end
			if ($urandom_range(0, 4) == 0) begin
				tmp.src = $urandom_range(n, 1023);
				tmp.dst = $urandom_range(0, 1023);
				tmp.weight = $urandom_range(0, 65535);
				edges = {edges, tmp};
			end
			if (edges.size() == 0) begin
				tmp.src = root;
				tmp.dst = root;
				tmp.weight = $urandom_range(0, 65535);
				edges = {edges, tmp};
			end
			for (int i = edges.size() - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				tmp = edges[i];
				edges[i] = edges[j];
				edges[j] = tmp;
			end
		end
		foreach (edges[i])
			send_edge(edges[i].src, edges[i].dst, edges[i].weight, i == edges.size() - 1);
		sent = edges.size();
	endtask

	// Directed table: register extremes, ignored index, clamping, a root
	// outside the graph, out-of-range endpoints, self-loops, a two-node cycle
	// that forces a contraction, and weight extremes.
	row_t directed_rows[] = '{
		'{ROW_CFG,  CFG_NODE_COUNT, 1,    0,     0, 0, 0,     0},
		'{ROW_EDGE, 0,    0,    0,     1, 1, 0,     0},
		'{ROW_CFG,  CFG_NODE_COUNT, 2,    0,     0, 0, 0,     0},
		'{ROW_CFG,  CFG_ROOT_NODE,  0,    0,     0, 0, 0,     0},
		'{ROW_EDGE, 0,    1,    65535, 1, 1, 65535, 0},
		'{ROW_EDGE, 1,    0,    5,     1, 1, 0,     1},
		'{ROW_CFG,  CFG_ROOT_NODE,  1023, 0,     0, 0, 0,     0},
		'{ROW_EDGE, 0,    1,    3,     1, 1, 0,     1},
		'{ROW_CFG,  CFG_SPARE,      7,    0,     0, 0, 0,     0},
		'{ROW_CFG,  CFG_ROOT_NODE,  0,    0,     0, 0, 0,     0},
		'{ROW_CFG,  CFG_NODE_COUNT, 0,    0,     0, 0, 0,     0},
		'{ROW_EDGE, 1023, 1023, 65535, 1, 1, 0,     0},
		'{ROW_CFG,  CFG_NODE_COUNT, 2047, 0,     0, 0, 0,     0},
		'{ROW_EDGE, 0,    1,    1,     1, 1, 0,     1},
		'{ROW_CFG,  CFG_NODE_COUNT, 3,    0,     0, 0, 0,     0},
		'{ROW_CFG,  CFG_ROOT_NODE,  2,    0,     0, 0, 0,     0},
		'{ROW_EDGE, 0,    1,    2,     0, 0, 0,     0},
		'{ROW_EDGE, 1,    0,    3,     0, 0, 0,     0},
		'{ROW_EDGE, 0,    0,    1,     0, 0, 0,     0},
		'{ROW_EDGE, 1,    1,    0,     0, 0, 0,     0},
		'{ROW_EDGE, 0,    3,    0,     0, 0, 0,     0},
		'{ROW_EDGE, 682,  341,  0,     0, 0, 0,     0},
		'{ROW_EDGE, 2,    0,    10,    0, 0, 0,     0},
		'{ROW_EDGE, 2,    1,    20,    1, 0, 0,     0},
		'{ROW_CFG,  CFG_NODE_COUNT, 4,    0,     0, 0, 0,     0},
		'{ROW_CFG,  CFG_ROOT_NODE,  2047, 0,     0, 0, 0,     0},
		'{ROW_EDGE, 0,    1,    43690, 0, 0, 0,     0},
		'{ROW_EDGE, 1,    2,    21845, 0, 0, 0,     0},
		'{ROW_EDGE, 2,    3,    0,     0, 0, 0,     0},
		'{ROW_EDGE, 3,    1,    1,     0, 0, 0,     0},
		'{ROW_EDGE, 0,    3,    65535, 1, 0, 0,     0}
	};

	// Stimulus and final verdict.
	initial begin
		answer_t typed_ans;
		int random_items, phase, sent, pick;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				drain();
				write_reg(CFG_INDEX_BITS'(directed_rows[i].a), directed_rows[i].b);
			end else begin
				typed_ans.total = TOTAL_BITS'(directed_rows[i].total);
				typed_ans.impossible = directed_rows[i].impossible;
				send_edge(directed_rows[i].a, directed_rows[i].b, directed_rows[i].weight,
					directed_rows[i].last, directed_rows[i].typed, typed_ans);
			end
		end

		// Random phases: new registers after a drain, then a few graphs.
		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			drain();
			quiet = phase >= 12 && phase < 20;
			pick = $urandom_range(99);
			if (pick < 85) begin
				write_reg(CFG_NODE_COUNT, $urandom_range(1, 12));
				if ($urandom_range(19) == 0)
					write_reg(CFG_ROOT_NODE, $urandom_range(0, 2047));
				else
					write_reg(CFG_ROOT_NODE, $urandom_range(0, model_node_count - 1));
			end else begin
				case ($urandom_range(0, 3))
					0: write_reg(CFG_NODE_COUNT, 0);
					1: write_reg(CFG_NODE_COUNT, 2047);
					2: write_reg(CFG_NODE_COUNT, 1024);
					default: write_reg(CFG_NODE_COUNT, 1025);
				endcase
				write_reg(CFG_ROOT_NODE, $urandom_range(0, 2047));
			end
			// Once, the result side stops for a long while so that a finished solve
			// has to wait and the unit has to stall the edge stream.
			if (phase == 10) hold_requests++;
			repeat (phase == 10 ? 4 : $urandom_range(1, 3)) begin
				send_random_graph(sent);
				random_items += sent;
			end
			phase++;
		end
		quiet = 0;
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_answers.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (pending_answers.size() != 0) begin
			$error("%0d answers never arrived", pending_answers.size());
			errors++;
		end

		$display("Sent %0d edge beats in %0d graphs, with clamped and out-of-range setups.",
			edges_sent, graphs_sent);
		$display("Checked %0d answers, %0d of them impossible, over %0d random phases.",
			answers_seen, impossible_seen, phase);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Result side: random back-pressure, plus the one long hold-off.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || $urandom_range(99) >= 14;
		end
	end

	// Answer checker: each beat against the oldest expectation.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			answers_seen++;
			if (m_tuser[0]) impossible_seen++;
			if (pending_answers.size() == 0) begin
				$error("answer beat with nothing expected: total %0d impossible %0d",
					m_tdata[TOTAL_BITS-1:0], m_tuser[0]);
				errors++;
			end else begin
				want = pending_answers.pop_front();
				if (m_tdata[TOTAL_BITS-1:0] !== want.total) begin
					$error("total_cost expected %0d got %0d", want.total,
						m_tdata[TOTAL_BITS-1:0]);
					errors++;
				end
				if (m_tuser[0] !== want.impossible) begin
					$error("impossible expected %0d got %0d", want.impossible, m_tuser[0]);
					errors++;
				end
			end
		end
	end

	// Watchdog: a long run of cycles without any beat means the unit hung.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("Timed out with %0d answers outstanding", pending_answers.size());
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule
`default_nettype wire
